// ----- sv/ust_pkg.sv -----
// Shared types and constants for the unordered set table.
package ust_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int ELEM_W       = 32;
    localparam int COUNT_W      = 7;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_REMOVE = 2'd1,
        FUNC_SEARCH = 2'd2
    } ust_func_t;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [ELEM_W-1:0] elem;
    } ust_req_t;

    typedef struct packed {
        logic               ok;
        logic               full_res;
        logic [COUNT_W-1:0] count;
        logic               empty_res;
    } ust_rsp_t;

endpackage

// ----- sv/ust_store.sv -----
// Single-port-write, single-port-read entry memory with registered read data.
module ust_store #(
    parameter int DEPTH  = ust_pkg::CAPACITY_DEF,
    parameter int ADDR_W = $clog2(ust_pkg::CAPACITY_DEF)
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [ADDR_W-1:0]          wr_addr,
    input  logic [ust_pkg::ELEM_W-1:0] wr_data,
    input  logic [ADDR_W-1:0]          rd_addr,
    output logic [ust_pkg::ELEM_W-1:0] rd_data
);
    import ust_pkg::*;

    logic [ELEM_W-1:0] mem [DEPTH];
    logic [ELEM_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- sv/unordered_set_table.sv -----
// Set of distinct 32-bit values held packed at the front of a table, one shared compare unit
// walking the table. An operation is taken when start is high and busy is low, and busy stays
// high until its result is done. Its one result beat appears on rsp with done high for exactly
// one cycle and must be taken then; the next operation may start in that same cycle. The scan
// reads the entries in order through the single memory read port until it finds a match or
// reaches the count; a successful remove then moves each later entry down one place, and a
// finish step updates the count and forms the result. An empty table or an unused operation
// code goes straight from the issue step to the finish step. With the default capacity of 64
// the longest operations are a miss and a successful remove in a full table.
module unordered_set_table #(
    parameter int CAPACITY = ust_pkg::CAPACITY_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ust_pkg::ust_req_t req,
    output logic              done,
    output ust_pkg::ust_rsp_t rsp
);
    import ust_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              found_reg, found_next;
    logic              done_reg, done_next;
    ust_rsp_t          rsp_reg, rsp_next;
    logic [1:0]        func_reg, func_next;
    logic [ELEM_W-1:0] elem_reg, elem_next;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [ELEM_W-1:0] wr_data;
    logic [IDX_W-1:0]  rd_addr;
    logic [ELEM_W-1:0] rd_data;

    logic              match;
    logic [CNT_W:0]    pos_plus1;
    logic [CNT_W:0]    pos_plus2;
    logic [CNT_W:0]    cnt_ext;
    logic              func_valid;

    ust_store #(
        .DEPTH  (CAPACITY),
        .ADDR_W (IDX_W)
    ) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // The one compare unit: the entry read last cycle against the value of this operation.
    assign match      = (rd_data == elem_reg);
    assign pos_plus1  = (CNT_W+1)'(idx_reg) + (CNT_W+1)'(1);
    assign pos_plus2  = (CNT_W+1)'(idx_reg) + (CNT_W+1)'(2);
    assign cnt_ext    = {1'b0, count_reg};
    assign func_valid = (req.func == FUNC_ADD) || (req.func == FUNC_REMOVE) ||
                        (req.func == FUNC_SEARCH);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        count_next = count_reg;
        found_next = found_reg;
        done_next  = 1'b0;
        rsp_next   = rsp_reg;
        func_next  = func_reg;
        elem_next  = elem_reg;
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = rd_data;
        rd_addr    = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    func_next  = req.func;
                    elem_next  = req.elem;
                    idx_next   = '0;
                    found_next = 1'b0;
                    if ((count_reg == '0) || !func_valid)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (match)
                begin
                    found_next = 1'b1;
                    if ((func_reg == FUNC_REMOVE) && (pos_plus1 < cnt_ext))
                    begin
                        rd_addr    = IDX_W'(pos_plus1);
                        state_next = ST_SHIFT;
                    end
                    else
                    begin
                        state_next = ST_FINISH;
                    end
                end
                else if (pos_plus1 < cnt_ext)
                begin
                    idx_next = IDX_W'(pos_plus1);
                    rd_addr  = IDX_W'(pos_plus1);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_SHIFT:
            begin
                // The entry above the hole arrived this cycle; drop it one place down.
                wr_en   = 1'b1;
                wr_addr = idx_reg;
                wr_data = rd_data;
                if (pos_plus2 < cnt_ext)
                begin
                    idx_next = IDX_W'(pos_plus1);
                    rd_addr  = IDX_W'(pos_plus2);
                end
                else
                begin
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                rsp_next.ok       = 1'b0;
                rsp_next.full_res = 1'b0;
                unique case (func_reg)
                    FUNC_ADD:
                    begin
                        if (!found_reg)
                        begin
                            if (cnt_ext >= (CNT_W+1)'(CAPACITY))
                            begin
                                rsp_next.full_res = 1'b1;
                            end
                            else
                            begin
                                wr_en       = 1'b1;
                                wr_addr     = count_reg[IDX_W-1:0];
                                wr_data     = elem_reg;
                                count_next  = count_reg + CNT_W'(1);
                                rsp_next.ok = 1'b1;
                            end
                        end
                    end
                    FUNC_REMOVE:
                    begin
                        if (found_reg)
                        begin
                            count_next  = count_reg - CNT_W'(1);
                            rsp_next.ok = 1'b1;
                        end
                    end
                    FUNC_SEARCH:
                    begin
                        rsp_next.ok = found_reg;
                    end
                    default:
                    begin
                        rsp_next.ok = 1'b0;
                    end
                endcase
                rsp_next.count     = COUNT_W'(count_next);
                rsp_next.empty_res = (count_next == '0);
                done_next          = 1'b1;
                state_next         = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
            count_reg <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            count_reg <= count_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        func_reg <= func_next;
        elem_reg <= elem_next;
    end

    assign busy = (state_reg != ST_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_ext <= (CNT_W+1)'(CAPACITY))
        else $error("count exceeds capacity");

    a_count_only_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(count_reg) |-> (done_reg && $past(state_reg == ST_FINISH)))
        else $error("count changed outside the finish step");

    a_shift_only_remove: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT) |-> (found_reg && (func_reg == FUNC_REMOVE)))
        else $error("shift entered for an operation other than a found remove");

    a_full_excludes_ok: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(rsp_reg.ok && rsp_reg.full_res))
        else $error("result reports both success and full");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy))
        else $error("result beat without an operation in progress");

endmodule

// ----- sim/tb_unordered_set_table.sv -----
// Self-checking testbench for the unordered set table: shadow set, random beats and gaps.
module tb_unordered_set_table;
    import ust_pkg::*;

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         DRAIN_WAIT  = 140;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     start = 1'b0;
    logic     busy;
    ust_req_t req = '0;
    logic     done;
    ust_rsp_t rsp;

    // Values currently held, in table order, and the results still owed by the block.
    logic [ELEM_W-1:0] shadow_set[$];
    ust_rsp_t          pending_rsp[$];
    ust_rsp_t          owed_rsp;

    int  mismatches = 0;
    int  cycles = 0;
    int  burst_left = 0;
    bit  no_gap = 1'b0;

    unordered_set_table DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Applies one operation to the shadow set and returns the result it should produce.
    function automatic ust_rsp_t apply_set_op(input logic [1:0] f, input logic [ELEM_W-1:0] v);
        ust_rsp_t r;
        int       pos;
        r   = '0;
        pos = -1;
        foreach (shadow_set[i])
        begin
            if (pos < 0 && shadow_set[i] == v)
                pos = i;
        end
        case (f)
            FUNC_ADD:
            begin
                if (pos < 0)
                begin
                    if (shadow_set.size() >= CAPACITY_DEF)
                        r.full_res = 1'b1;
                    else
                    begin
                        shadow_set.push_back(v);
                        r.ok = 1'b1;
                    end
                end
            end
            FUNC_REMOVE:
            begin
                if (pos >= 0)
                begin
                    shadow_set.delete(pos);
                    r.ok = 1'b1;
                end
            end
            FUNC_SEARCH:
                r.ok = (pos >= 0);
            default: ;
        endcase
        r.count     = COUNT_W'(shadow_set.size());
        r.empty_res = (shadow_set.size() == 0);
        return r;
    endfunction

    // Sends one request beat after a random gap and records its expected result on acceptance.
    task automatic send_op(input logic [1:0] f, input logic [ELEM_W-1:0] v);
        int gap;
        if (burst_left == 0)
        begin
            no_gap     = ($urandom_range(0, 3) == 0);
            burst_left = 32;
        end
        burst_left--;
        gap = no_gap ? 0 : $urandom_range(0, 8);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start    <= 1'b1;
        req.func <= f;
        req.elem <= v;
        do @(posedge clk); while (busy);
        pending_rsp.push_back(apply_set_op(f, v));
    endtask

    function automatic logic [ELEM_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        if (r <= 4 && shadow_set.size() > 0)
            return shadow_set[$urandom_range(0, shadow_set.size() - 1)];
        if (r <= 6)
            return $urandom_range(0, 1) ? $urandom_range(0, 15) : -$urandom_range(1, 16);
        if (r == 7)
            case ($urandom_range(0, 3))
                0:       return 32'h0000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h8000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        return $urandom();
    endfunction

    function automatic logic [1:0] pick_func();
        int r;
        r = $urandom_range(0, 19);
        if (r <= 7)
            return FUNC_ADD;
        if (r <= 13)
            return FUNC_REMOVE;
        if (r <= 18)
            return FUNC_SEARCH;
        return FUNC_UNUSED;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (pending_rsp.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result beat: ok=%0b full=%0b count=%0d empty=%0b",
                             rsp.ok, rsp.full_res, rsp.count, rsp.empty_res);
            end
            else
            begin
                owed_rsp = pending_rsp.pop_front();
                if (rsp.ok !== owed_rsp.ok || rsp.full_res !== owed_rsp.full_res ||
                    rsp.count !== owed_rsp.count || rsp.empty_res !== owed_rsp.empty_res)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"result mismatch at cycle %0d: ",
                                  "expected ok=%0b full=%0b count=%0d empty=%0b, ",
                                  "got ok=%0b full=%0b count=%0d empty=%0b"},
                                 cycles, owed_rsp.ok, owed_rsp.full_res, owed_rsp.count,
                                 owed_rsp.empty_res, rsp.ok, rsp.full_res, rsp.count,
                                 rsp.empty_res);
                end
            end
        end
    end

    // Empty-table cases, extreme values, duplicates, middle/first/last removal, unused code.
    task automatic test_directed();
        send_op(FUNC_SEARCH, 32'h0000_0000);
        send_op(FUNC_REMOVE, 32'h0000_0005);
        send_op(FUNC_UNUSED, 32'h0000_0000);
        send_op(FUNC_ADD,    32'h0000_0000);
        send_op(FUNC_ADD,    32'h7FFF_FFFF);
        send_op(FUNC_ADD,    32'h8000_0000);
        send_op(FUNC_ADD,    32'hFFFF_FFFF);
        send_op(FUNC_ADD,    32'h0000_0000);
        send_op(FUNC_SEARCH, 32'h8000_0000);
        send_op(FUNC_SEARCH, 32'h0000_0001);
        send_op(FUNC_REMOVE, 32'h7FFF_FFFF);
        send_op(FUNC_SEARCH, 32'hFFFF_FFFF);
        send_op(FUNC_REMOVE, 32'h1234_5678);
        send_op(FUNC_UNUSED, 32'hFFFF_FFFF);
        send_op(FUNC_REMOVE, 32'h0000_0000);
        send_op(FUNC_REMOVE, 32'hFFFF_FFFF);
        send_op(FUNC_REMOVE, 32'h8000_0000);
        send_op(FUNC_SEARCH, 32'h8000_0000);
    endtask

    // Fills the table to capacity, probes the full behavior, then drains it in random order.
    task automatic test_fill_drain();
        int i;
        while (shadow_set.size() < CAPACITY_DEF)
            send_op(FUNC_ADD, $urandom());
        for (i = 0; i < 3; i++)
            send_op(FUNC_ADD, $urandom());
        send_op(FUNC_ADD, shadow_set[$urandom_range(0, CAPACITY_DEF - 1)]);
        send_op(FUNC_ADD, shadow_set[CAPACITY_DEF - 1]);
        send_op(FUNC_SEARCH, shadow_set[CAPACITY_DEF - 1]);
        send_op(FUNC_UNUSED, $urandom());
        // Removing the first entry of a full table gives the longest shift.
        send_op(FUNC_REMOVE, shadow_set[0]);
        send_op(FUNC_ADD, $urandom());
        while (shadow_set.size() > 0)
        begin
            if ($urandom_range(0, 4) == 0)
                send_op(FUNC_SEARCH, pick_value());
            else
                send_op(FUNC_REMOVE, shadow_set[$urandom_range(0, shadow_set.size() - 1)]);
        end
    endtask

    task automatic test_random_mix(input int n_ops);
        repeat (n_ops)
            send_op(pick_func(), pick_value());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_drain();
        test_random_mix(350);
        test_fill_drain();
        start <= 1'b0;
        while (pending_rsp.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && pending_rsp.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
